/* design/dwrf_pkg.sv */
// shared widths, reset values, register codes and helpers of the depth window range filter
package dwrf_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 2048;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned IW_W       = 12;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MIN_IMAGE_WIDTH = 3;

  localparam logic [THR_W-1:0] THR_RESET = 16'd15;
  localparam logic [IW_W-1:0]  IW_RESET  = 12'd640;

  typedef logic [DATA_W-1:0] pix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD   = 1'b0,
    CFG_IMAGE_WIDTH = 1'b1
  } cfg_reg_t;

  // per-word status carried down the pipe
  typedef struct packed {
    logic valid;     // a real delayed pixel result
    logic interior;  // valid and off the frame border
  } flags_t;

  function automatic pix_t pmin(input pix_t a, input pix_t b);
    pmin = (a < b) ? a : b;
  endfunction

  function automatic pix_t pmax(input pix_t a, input pix_t b);
    pmax = (a > b) ? a : b;
  endfunction

endpackage

/* design/depth_window_range_filter.sv */
// 3x3 local range depth filter: line buffer memory, window and min/max pipeline
// throughput: one word per cycle while out_stall is low, set by the single read-modify-write
//   of the line buffer memory per pixel (read at accept, write back one stage later)
// output: after accept a word passes s1, s2 and s3 and its result is registered on the output;
//   it belongs to the pixel image_width+1 input words earlier
// reset: synchronous active-low; clears counters, window, pipe valids and config registers;
//   the line buffer memory is not cleared, so no clearing pass is needed after reset
module depth_window_range_filter
  import dwrf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_W-1:0]     in_depth_in,
  input  logic                  in_frame_start,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_W-1:0]     out_depth_out,
  output logic                  out_out_valid,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // column address width and a compare width that holds both the config value and MAX_WIDTH
  localparam int unsigned AW     = $clog2(MAX_WIDTH);
  localparam int unsigned EW_RAW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW     = (EW_RAW > IW_W) ? EW_RAW : IW_W;
  localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);
  localparam logic [EW-1:0] MIN_W_E = EW'(MIN_IMAGE_WIDTH);

  // ---------------------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------------------
  logic [THR_W-1:0] thr_r;
  logic [IW_W-1:0]  width_r;
  logic [EW-1:0]    width_e;
  logic [EW-1:0]    w_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THR_RESET;
      width_r <= IW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:   thr_r   <= cfg_data[THR_W-1:0];
        CFG_IMAGE_WIDTH: width_r <= cfg_data[IW_W-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range widths act as the nearest legal width
  always_comb begin
    width_e = EW'(width_r);
    if (width_e < MIN_W_E) begin
      w_eff = MIN_W_E;
    end else if (width_e > MAX_W_E) begin
      w_eff = MAX_W_E;
    end else begin
      w_eff = width_e;
    end
  end

  // ---------------------------------------------------------------------------------------
  // pipe handshake: s1 (memory read data) -> s2 (window) -> s3 (min/max) -> output register
  // each stage loads when empty or when its word moves on in the same cycle
  // ---------------------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic rdy_out, rdy3, rdy2, rdy1;
  logic mv1, mv2, mv3;
  logic acc;

  assign rdy_out = !out_v_r || !out_stall;
  assign mv3     = s3_v_r && rdy_out;
  assign rdy3    = !s3_v_r || rdy_out;
  assign mv2     = s2_v_r && rdy3;
  assign rdy2    = !s2_v_r || rdy3;
  assign mv1     = s1_v_r && rdy2;
  assign rdy1    = !s1_v_r || rdy2;
  assign in_stall = !rdy1;
  assign acc     = in_valid && rdy1;

  // ---------------------------------------------------------------------------------------
  // column and row position of the incoming pixel
  // ---------------------------------------------------------------------------------------
  logic [AW-1:0] col_r, col_nxt, col_cur;
  logic [1:0]    row_r, row_nxt, row_cur;
  logic [EW-1:0] col_inc;
  logic          row_end;
  logic          pix_ok, on_border;
  flags_t        in_flags;

  always_comb begin
    col_cur = in_frame_start ? '0 : col_r;
    row_cur = in_frame_start ? 2'd0 : row_r;
    col_inc = EW'(col_cur) + EW'(1);
    row_end = (col_inc >= w_eff);
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = (row_cur == 2'd3) ? row_cur : row_cur + 2'd1;  // saturates at three
      end else begin
        col_nxt = col_inc[AW-1:0];
        row_nxt = row_cur;
      end
    end
    // result exists once the input is past the first row and the first column of the second row
    pix_ok    = (row_cur >= 2'd2) || (row_cur == 2'd1 && col_cur != '0);
    on_border = (row_cur == 2'd1) || (col_cur <= AW'(1));
    in_flags.valid    = pix_ok;
    in_flags.interior = pix_ok && !on_border;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= 2'd0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------------------
  // line buffer memory: each entry packs {row above, row two above} for one column
  // read at accept, written back when the word leaves s1
  // ---------------------------------------------------------------------------------------
  logic [2*DATA_W-1:0] lb_mem [MAX_WIDTH];
  logic [2*DATA_W-1:0] rd_r;

  logic [AW-1:0] s1_col_r;
  pix_t          s1_px_r;
  flags_t        s1_flags_r;
  logic          s1_fwd_r;
  pix_t          s1_fa_r, s1_fb_r;
  pix_t          up1_eff, up2_eff;
  logic          fwd_hit;

  // the word leaving s1 writes the same edge the next word reads; same column needs a bypass
  assign fwd_hit = mv1 && (s1_col_r == col_cur);
  assign up1_eff = s1_fwd_r ? s1_fa_r : rd_r[2*DATA_W-1:DATA_W];
  assign up2_eff = s1_fwd_r ? s1_fb_r : rd_r[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r <= lb_mem[col_cur];
    end
    if (mv1) begin
      lb_mem[s1_col_r] <= {s1_px_r, up1_eff};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s1_fwd_r <= 1'b0;
    end else if (acc) begin
      s1_v_r   <= 1'b1;
      s1_fwd_r <= fwd_hit;
    end else if (mv1) begin
      s1_v_r   <= 1'b0;
      s1_fwd_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r   <= col_cur;
      s1_px_r    <= in_depth_in;
      s1_flags_r <= in_flags;
      s1_fa_r    <= s1_px_r;   // bypass copy of what the departing word writes
      s1_fb_r    <= up1_eff;
    end
  end

  // ---------------------------------------------------------------------------------------
  // 3x3 window: rows top to bottom, columns left to right, new column enters on the right
  // ---------------------------------------------------------------------------------------
  pix_t   win_r [9];
  flags_t s2_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else if (mv1) begin
      for (int k = 0; k < 9; k += 3) begin
        win_r[k]   <= win_r[k+1];
        win_r[k+1] <= win_r[k+2];
      end
      win_r[2] <= up2_eff;
      win_r[5] <= up1_eff;
      win_r[8] <= s1_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (mv1) begin
      s2_v_r <= 1'b1;
    end else if (mv2) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      s2_flags_r <= s1_flags_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // window min and max as a four-level compare tree
  // ---------------------------------------------------------------------------------------
  pix_t mn01, mn23, mn45, mn67, mn03, mn47, mn07, win_mn;
  pix_t mx01, mx23, mx45, mx67, mx03, mx47, mx07, win_mx;

  always_comb begin
    mn01   = pmin(win_r[0], win_r[1]);
    mn23   = pmin(win_r[2], win_r[3]);
    mn45   = pmin(win_r[4], win_r[5]);
    mn67   = pmin(win_r[6], win_r[7]);
    mn03   = pmin(mn01, mn23);
    mn47   = pmin(mn45, mn67);
    mn07   = pmin(mn03, mn47);
    win_mn = pmin(mn07, win_r[8]);
    mx01   = pmax(win_r[0], win_r[1]);
    mx23   = pmax(win_r[2], win_r[3]);
    mx45   = pmax(win_r[4], win_r[5]);
    mx67   = pmax(win_r[6], win_r[7]);
    mx03   = pmax(mx01, mx23);
    mx47   = pmax(mx45, mx67);
    mx07   = pmax(mx03, mx47);
    win_mx = pmax(mx07, win_r[8]);
  end

  pix_t   s3_mn_r, s3_mx_r, s3_c_r;
  flags_t s3_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (mv2) begin
      s3_v_r <= 1'b1;
    end else if (mv3) begin
      s3_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv2) begin
      s3_mn_r    <= win_mn;
      s3_mx_r    <= win_mx;
      s3_c_r     <= win_r[4];
      s3_flags_r <= s2_flags_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // range test and output register
  // centre lies between min and max, so both differences are non-negative
  // ---------------------------------------------------------------------------------------
  pix_t diff_hi, diff_lo;
  logic keep;
  pix_t out_depth_r;
  logic out_pv_r;

  assign diff_hi = s3_mx_r - s3_c_r;
  assign diff_lo = s3_c_r - s3_mn_r;
  assign keep    = s3_flags_r.interior && (diff_hi < thr_r) && (diff_lo < thr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (mv3) begin
      out_v_r <= 1'b1;
    end else if (rdy_out) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv3) begin
      out_depth_r <= keep ? s3_c_r : '0;
      out_pv_r    <= s3_flags_r.valid;
    end
  end

  assign out_valid     = out_v_r;
  assign out_depth_out = out_depth_r;
  assign out_out_valid = out_pv_r;

  // ---------------------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------------------
  a_frame_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_frame_start |=> col_r == AW'(1) && row_r == 2'd0)
    else $error("position after frame start is wrong");

  a_row_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    row_r == 2'd3 && !(acc && in_frame_start) |=> row_r == 2'd3)
    else $error("row count left saturation");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_pv_r |-> out_depth_r == '0)
    else $error("word without a pixel result carries nonzero depth");

  a_bypass_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fwd_r |-> s1_v_r)
    else $error("line buffer bypass set with empty read stage");

  a_accept_frees_s1: assert property (@(posedge clk) disable iff (!rst_n)
    acc && s1_v_r |-> mv1)
    else $error("read stage overwritten before write back");

endmodule
